@@ hdl/tnrc_pkg.sv @@
`default_nettype none

package tnrc_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int RATE_W = 40;
    localparam int TICK_W = 63;
    localparam int IVL_W = 30;
    localparam int ADDR_W = 3;

    localparam logic [IVL_W-1:0] IVL_RESET = IVL_W'(1000000);
    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    localparam logic [1:0] ACT_BASE = 2'd0;
    localparam logic [1:0] ACT_RATE = 2'd1;
    localparam logic [1:0] ACT_CAL = 2'd2;

    localparam logic [0:0] REG_INTERVAL = 1'b0;

    typedef struct packed {
        logic [1:0]        action;
        logic [TICK_W-1:0] tick_count;
        logic [TICK_W-1:0] system_ns;
    } t_in_word;

    typedef struct packed {
        logic [RATE_W-1:0]  ns_per_tick_q32;
        logic [TICK_W-1:0]  next_calibration_tick;
        logic signed [63:0] corrected_ns;
        logic signed [63:0] ns_error;
        logic               status;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CV_LD,
        S_CV_MUL,
        S_CV_FIN,
        S_ERR,
        S_A1_SET,
        S_A1_DIV,
        S_A1_FIN,
        S_A2_SUB,
        S_A2_DEN,
        S_A2_MUL,
        S_A2_DLD,
        S_A2_DIV,
        S_A2_EXP,
        S_A2_MLD2,
        S_A2_MUL2,
        S_A2_DLD2,
        S_A2_DIV2,
        S_A2_NR,
        S_SV_SET,
        S_SV_DIV,
        S_SV_FIN,
        S_DONE
    } t_state;

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] mag(input logic signed [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic signed [63:0] to_sgn(input logic neg, input logic [127:0] m);
        if (neg) begin
            if (m[127:63] != '0) begin
                return S64_MIN;
            end
            return 64'd0 - m[63:0];
        end
        if (m[127:63] != '0) begin
            return S64_MAX;
        end
        return m[63:0];
    endfunction

endpackage

`default_nettype wire

@@ hdl/tick_to_ns_rate_calibrator.sv @@
`default_nettype none

// Tick-to-ns rate calibrator. Takes paired (tick, reference ns) samples: action 0 stores a
// base sample, action 1 sets the initial Q8.FRAC_BITS rate from the base sample, action 2
// converts the tick with the current line, predicts the error one interval ahead, rescales
// the rate and rebases. One result word per input word. All products and quotients run on one
// shared bit-serial multiplier and one restoring divider, one item at a time: a new input word
// is taken only after the result word of the last one is registered. A zero divisor, or tick
// and ns deltas of opposite sign for action 1, report status 1 and leave the state as it was.
// The interval register sits at byte address 0 of the APB port.
module tick_to_ns_rate_calibrator
    import tnrc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_word          i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_word              o_out_word,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_state r_state, n_state;

    logic [1:0]         r_act, n_act;
    logic [TICK_W-1:0]  r_tick, n_tick;
    logic [TICK_W-1:0]  r_ns, n_ns;
    logic               r_neg, n_neg;
    logic               r_numneg, n_numneg;
    logic signed [63:0] r_tmp, n_tmp;
    logic signed [63:0] r_corr, n_corr;
    logic signed [63:0] r_err, n_err;
    logic signed [63:0] r_exp, n_exp;
    logic               r_status, n_status;

    logic [127:0]       r_acc, n_acc;
    logic [63:0]        r_opb, n_opb;
    logic [63:0]        r_rem, n_rem;
    logic [6:0]         r_cnt, n_cnt;

    logic [TICK_W-1:0]  r_sv_bt, n_sv_bt;
    logic signed [63:0] r_sv_bn, n_sv_bn;
    logic [TICK_W-1:0]  r_sv_sn, n_sv_sn;
    logic [RATE_W-1:0]  r_sv_rate, n_sv_rate;

    logic [IVL_W-1:0]   r_interval, n_interval;
    logic [TICK_W-1:0]  r_base_tick, n_base_tick;
    logic signed [63:0] r_base_ns, n_base_ns;
    logic signed [63:0] r_base_err, n_base_err;
    logic [RATE_W-1:0]  r_rate, n_rate;
    logic [TICK_W-1:0]  r_due, n_due;
    logic [TICK_W-1:0]  r_first_tick, n_first_tick;
    logic [TICK_W-1:0]  r_first_ns, n_first_ns;

    logic               r_ovld, n_ovld;
    t_out_word          r_out, n_out;

    logic [64:0]        mul_sum;
    logic [64:0]        div_sh;
    logic               div_ge;
    logic               mul_last;
    logic               div_last;
    logic signed [63:0] w_d;
    logic signed [63:0] w_dt;
    logic signed [63:0] w_dn;
    logic signed [63:0] w_den;
    logic signed [63:0] w_num;
    logic signed [31:0] w_iv2;
    logic [31:0]        w_iv2_mag;
    logic [RATE_W-1:0]  w_rate;
    logic [RATE_W:0]    w_rsum;
    logic signed [63:0] w_s;
    logic               cfg_wr;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_word = r_out;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_INTERVAL) ? {{(32-IVL_W){1'b0}}, r_interval} : 32'd0;

    assign mul_sum = {1'b0, r_acc[127:64]} + (r_acc[0] ? {1'b0, r_opb} : 65'd0);
    assign div_sh = {r_rem, r_acc[127]};
    assign div_ge = (div_sh >= {1'b0, r_opb});
    assign mul_last = (r_cnt[5:0] == 6'd63);
    assign div_last = (r_cnt == 7'd127);

    assign w_d = {1'b0, r_tick} - {1'b0, r_base_tick};
    assign w_dt = {1'b0, r_tick} - {1'b0, r_first_tick};
    assign w_dn = {1'b0, r_ns} - {1'b0, r_first_ns};
    assign w_den = sat_add(r_tmp, r_base_err);
    assign w_num = sat_sub(r_err, r_base_err);
    assign w_iv2 = $signed({2'b00, r_interval}) - 32'sd1000;
    assign w_iv2_mag = w_iv2[31] ? (32'd0 - w_iv2) : w_iv2;
    assign w_rate = (r_acc[127:RATE_W] != '0) ? RATE_MAX : r_acc[RATE_W-1:0];
    assign w_rsum = {1'b0, r_rate} + {1'b0, r_acc[RATE_W-1:0]};
    assign w_s = sat_add({1'b0, r_sv_bt}, to_sgn(r_neg, r_acc));

    always_comb begin
        n_state = r_state;
        n_act = r_act;
        n_tick = r_tick;
        n_ns = r_ns;
        n_neg = r_neg;
        n_numneg = r_numneg;
        n_tmp = r_tmp;
        n_corr = r_corr;
        n_err = r_err;
        n_exp = r_exp;
        n_status = r_status;
        n_acc = r_acc;
        n_opb = r_opb;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_sv_bt = r_sv_bt;
        n_sv_bn = r_sv_bn;
        n_sv_sn = r_sv_sn;
        n_sv_rate = r_sv_rate;
        n_interval = r_interval;
        n_base_tick = r_base_tick;
        n_base_ns = r_base_ns;
        n_base_err = r_base_err;
        n_rate = r_rate;
        n_due = r_due;
        n_first_tick = r_first_tick;
        n_first_ns = r_first_ns;
        n_ovld = r_ovld;
        n_out = r_out;

        if (cfg_wr && paddr[2] == REG_INTERVAL) begin
            n_interval = pwdata[IVL_W-1:0];
        end
        if (r_ovld && i_out_ready) begin
            n_ovld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_act = i_in_word.action;
                    n_tick = i_in_word.tick_count;
                    n_ns = i_in_word.system_ns;
                    n_status = 1'b0;
                    n_state = S_CV_LD;
                end
            end
            S_CV_LD: begin
                n_neg = w_d[63];
                n_opb = mag(w_d);
                n_acc = {88'd0, r_rate};
                n_cnt = '0;
                n_state = S_CV_MUL;
            end
            S_CV_MUL: begin
                n_acc = {mul_sum, r_acc[63:1]};
                n_cnt = r_cnt + 7'd1;
                if (mul_last) begin
                    n_state = S_CV_FIN;
                end
            end
            S_CV_FIN: begin
                n_corr = sat_add(r_base_ns, to_sgn(r_neg, r_acc >> FRAC_BITS));
                n_state = S_ERR;
            end
            S_ERR: begin
                n_err = sat_sub(r_corr, {1'b0, r_ns});
                case (r_act)
                    ACT_BASE: begin
                        n_first_tick = r_tick;
                        n_first_ns = r_ns;
                        n_state = S_DONE;
                    end
                    ACT_RATE: n_state = S_A1_SET;
                    ACT_CAL:  n_state = S_A2_SUB;
                    default:  n_state = S_DONE;
                endcase
            end
            S_A1_SET: begin
                if (w_dt == '0 || (w_dn != '0 && w_dn[63] != w_dt[63])) begin
                    n_status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_acc = {64'd0, mag(w_dn)} << FRAC_BITS;
                    n_opb = mag(w_dt);
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = S_A1_DIV;
                end
            end
            S_A1_DIV, S_A2_DIV, S_A2_DIV2, S_SV_DIV: begin
                n_rem = div_ge ? (div_sh[63:0] - r_opb) : div_sh[63:0];
                n_acc = {r_acc[126:0], div_ge};
                n_cnt = r_cnt + 7'd1;
                if (div_last) begin
                    case (r_state)
                        S_A1_DIV:  n_state = S_A1_FIN;
                        S_A2_DIV:  n_state = S_A2_EXP;
                        S_A2_DIV2: n_state = S_A2_NR;
                        default:   n_state = S_SV_FIN;
                    endcase
                end
            end
            S_A1_FIN: begin
                if (w_rate == '0) begin
                    n_status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_sv_bt = r_first_tick;
                    n_sv_bn = {1'b0, r_first_ns};
                    n_sv_sn = r_first_ns;
                    n_sv_rate = w_rate;
                    n_state = S_SV_SET;
                end
            end
            S_A2_SUB: begin
                n_tmp = sat_sub({1'b0, r_ns}, r_base_ns);
                n_state = S_A2_DEN;
            end
            S_A2_DEN: begin
                if (w_den == '0 || r_interval == '0) begin
                    n_status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_tmp = w_den;
                    n_numneg = w_num[63];
                    n_opb = mag(w_num);
                    n_acc = {{(128-IVL_W){1'b0}}, r_interval};
                    n_cnt = '0;
                    n_state = S_A2_MUL;
                end
            end
            S_A2_MUL, S_A2_MUL2: begin
                n_acc = {mul_sum, r_acc[63:1]};
                n_cnt = r_cnt + 7'd1;
                if (mul_last) begin
                    n_state = (r_state == S_A2_MUL) ? S_A2_DLD : S_A2_DLD2;
                end
            end
            S_A2_DLD: begin
                n_opb = mag(r_tmp);
                n_neg = r_numneg ^ r_tmp[63];
                n_rem = '0;
                n_cnt = '0;
                n_state = S_A2_DIV;
            end
            S_A2_EXP: begin
                n_exp = sat_add(r_err, to_sgn(r_neg, r_acc));
                n_state = S_A2_MLD2;
            end
            S_A2_MLD2: begin
                n_opb = {24'd0, r_rate};
                n_acc = {64'd0, mag(r_exp)};
                n_cnt = '0;
                n_state = S_A2_MUL2;
            end
            S_A2_DLD2: begin
                n_opb = {{(64-IVL_W){1'b0}}, r_interval};
                n_rem = '0;
                n_cnt = '0;
                n_state = S_A2_DIV2;
            end
            S_A2_NR: begin
                if (!r_exp[63] && r_exp != '0) begin
                    if (r_acc[127:RATE_W] != '0 || r_acc[RATE_W-1:0] >= r_rate) begin
                        n_sv_rate = '0;
                    end else begin
                        n_sv_rate = r_rate - r_acc[RATE_W-1:0];
                    end
                end else begin
                    if (r_acc[127:RATE_W] != '0 || w_rsum[RATE_W]) begin
                        n_sv_rate = RATE_MAX;
                    end else begin
                        n_sv_rate = w_rsum[RATE_W-1:0];
                    end
                end
                n_sv_bt = r_tick;
                n_sv_bn = r_corr;
                n_sv_sn = r_ns;
                n_state = S_SV_SET;
            end
            S_SV_SET: begin
                if (r_sv_rate == '0) begin
                    n_status = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_neg = w_iv2[31];
                    n_acc = {96'd0, w_iv2_mag} << FRAC_BITS;
                    n_opb = {24'd0, r_sv_rate};
                    n_rem = '0;
                    n_cnt = '0;
                    n_state = S_SV_DIV;
                end
            end
            S_SV_FIN: begin
                n_due = w_s[63] ? '0 : w_s[62:0];
                n_base_err = sat_sub(r_sv_bn, {1'b0, r_sv_sn});
                n_base_tick = r_sv_bt;
                n_base_ns = r_sv_bn;
                n_rate = r_sv_rate;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovld || i_out_ready) begin
                    n_ovld = 1'b1;
                    n_out.ns_per_tick_q32 = r_rate;
                    n_out.next_calibration_tick = r_due;
                    n_out.corrected_ns = r_corr;
                    n_out.ns_error = r_err;
                    n_out.status = r_status;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld <= 1'b0;
            r_interval <= IVL_RESET;
            r_base_tick <= '0;
            r_base_ns <= '0;
            r_base_err <= '0;
            r_rate <= '0;
            r_due <= '0;
            r_first_tick <= '0;
            r_first_ns <= '0;
        end else begin
            r_state <= n_state;
            r_ovld <= n_ovld;
            r_interval <= n_interval;
            r_base_tick <= n_base_tick;
            r_base_ns <= n_base_ns;
            r_base_err <= n_base_err;
            r_rate <= n_rate;
            r_due <= n_due;
            r_first_tick <= n_first_tick;
            r_first_ns <= n_first_ns;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;
        r_tick <= n_tick;
        r_ns <= n_ns;
        r_neg <= n_neg;
        r_numneg <= n_numneg;
        r_tmp <= n_tmp;
        r_corr <= n_corr;
        r_err <= n_err;
        r_exp <= n_exp;
        r_status <= n_status;
        r_acc <= n_acc;
        r_opb <= n_opb;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_sv_bt <= n_sv_bt;
        r_sv_bn <= n_sv_bn;
        r_sv_sn <= n_sv_sn;
        r_sv_rate <= n_sv_rate;
        r_out <= n_out;
    end

endmodule

`default_nettype wire
